// ----- rtl/qsde_pkg.sv -----
// ----------------------------------------------------------------------------
// qsde_pkg
// Shared constants and types for the transition quadrilateral shape function
// evaluator: fixed-point widths, scale constants and the per-node result set.
// ----------------------------------------------------------------------------
package qsde_pkg;

  // Field widths.
  localparam int COORD_W = 16;
  localparam int MASK_W  = 8;
  localparam int NODE_W  = 3;
  localparam int OUT_W   = 17;
  localparam int N_NODES = 8;

  // Working width for terms held at scale 2^44 (magnitudes stay below 2^48).
  localparam int WIDE_W   = 52;
  // Shift that floors a scale 2^44 term down to scale 2^14.
  localparam int FLOOR_SH = 30;

  // One in Q1.14 and its square, at the widths where they are used.
  localparam logic signed [16:0] ONE_Q14 = 17'sd16384;
  localparam logic signed [31:0] ONE_SQ  = 32'sd268435456;

  // Saturation limits of a result value.
  localparam int OUT_MAX = 65535;
  localparam int OUT_MIN = -65536;

  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [OUT_W-1:0]  out_val_t;

  // Shape value and both natural derivatives of one node.
  typedef struct packed {
    out_val_t shape;
    out_val_t dxi;
    out_val_t deta;
  } node_res_t;

  // Everything the output sequencer needs for one input item.
  typedef struct packed {
    logic [MASK_W-1:0]          mask;
    node_res_t [N_NODES-1:0]    res;
  } node_set_t;

endpackage

// ----- rtl/qsde_in_if.sv -----
// ----------------------------------------------------------------------------
// qsde_in_if
// Input channel: one natural point and a node-presence mask per transaction.
// ----------------------------------------------------------------------------
interface qsde_in_if;
  logic                      valid;
  logic                      ready;
  logic signed [15:0]        xi_coord;
  logic signed [15:0]        eta_coord;
  logic [7:0]                node_mask;

  modport source (output valid, output xi_coord, output eta_coord, output node_mask,
                  input ready);
  modport sink   (input valid, input xi_coord, input eta_coord, input node_mask,
                  output ready);
endinterface

// ----- rtl/qsde_out_if.sv -----
// ----------------------------------------------------------------------------
// qsde_out_if
// Result channel: one present node's shape value and derivatives per
// transaction.
// ----------------------------------------------------------------------------
interface qsde_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         node_index;
  logic signed [16:0] shape_value;
  logic signed [16:0] deriv_xi;
  logic signed [16:0] deriv_eta;
  logic               last_node;

  modport source (output valid, output node_index, output shape_value,
                  output deriv_xi, output deriv_eta, output last_node, input ready);
  modport sink   (input valid, input node_index, input shape_value,
                  input deriv_xi, input deriv_eta, input last_node, output ready);
endinterface

// ----- rtl/qsde_arith.sv -----
// ----------------------------------------------------------------------------
// qsde_arith
// Six-stage arithmetic pipeline that evaluates all eight shape functions and
// their derivatives for one point, with midside masking, corner correction,
// flooring to scale 2^14 and saturation.
// ----------------------------------------------------------------------------
module qsde_arith (
  input  logic                 clk,
  input  logic                 rst,
  qsde_in_if.sink              items,
  output logic                 set_valid,
  input  logic                 set_ready,
  output qsde_pkg::node_set_t  set_data
);

  // Floor a scale 2^44 term to scale 2^14 and clamp it to the result range.
  function automatic qsde_pkg::out_val_t floor_sat(input qsde_pkg::wide_t v);
    qsde_pkg::wide_t s;
    s = v >>> qsde_pkg::FLOOR_SH;
    if (s > qsde_pkg::wide_t'(qsde_pkg::OUT_MAX)) begin
      s = qsde_pkg::wide_t'(qsde_pkg::OUT_MAX);
    end else if (s < qsde_pkg::wide_t'(qsde_pkg::OUT_MIN)) begin
      s = qsde_pkg::wide_t'(qsde_pkg::OUT_MIN);
    end
    return s[qsde_pkg::OUT_W-1:0];
  endfunction

  // Stage valid bits and per-stage advance enables.
  logic [6:1] v;
  logic [7:1] adv;

  // Stage 1 registers.
  logic signed [15:0] x1, y1;
  logic [7:0]         m1;
  logic signed [16:0] smx1, spx1, smy1, spy1;
  logic signed [31:0] xsq1, ysq1;

  // Stage 2 registers.
  logic [7:0]         m2;
  logic signed [16:0] smx2, spx2, smy2, spy2;
  logic signed [31:0] qx2, qy2;
  logic signed [33:0] pmm2, ppm2, ppp2, pmp2;
  logic signed [32:0] xsmy2, xspy2, yspx2, ysmx2;

  // Stage 3 registers.
  logic [7:0]         m3;
  logic signed [16:0] smx3, spx3, smy3, spy3;
  logic signed [31:0] qx3, qy3;
  logic signed [33:0] pmm3, ppm3, ppp3, pmp3;
  logic signed [32:0] xsmy3, xspy3, yspx3, ysmx3;
  logic signed [48:0] mq4_3, mq5_3, mq6_3, mq7_3;

  // Stage 4 and 5 registers: all terms at scale 2^44.
  logic [7:0]         m4, m5;
  qsde_pkg::wide_t    nv4 [8];
  qsde_pkg::wide_t    dx4 [8];
  qsde_pkg::wide_t    dy4 [8];
  qsde_pkg::wide_t    nv5 [8];
  qsde_pkg::wide_t    dx5 [8];
  qsde_pkg::wide_t    dy5 [8];

  // Stage 6 registers: final results.
  logic [7:0]                          m6;
  qsde_pkg::node_res_t [7:0]           res6;

  // Combinational values for the stage inputs.
  logic signed [16:0] smx_c, spx_c, smy_c, spy_c;
  qsde_pkg::wide_t    nv_c [8];
  qsde_pkg::wide_t    dx_c [8];
  qsde_pkg::wide_t    dy_c [8];
  qsde_pkg::wide_t    nvk_c [8];
  qsde_pkg::wide_t    dxk_c [8];
  qsde_pkg::wide_t    dyk_c [8];
  qsde_pkg::node_res_t [7:0] res_c;

  // A stage moves on when it is empty or the stage after it moves on.
  always_comb begin
    adv[7] = set_ready;
    for (int i = 6; i >= 1; i--) begin
      adv[i] = !v[i] || adv[i+1];
    end
  end

  // No transaction is taken while reset is held.
  assign items.ready = adv[1] && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[1]) v[1] <= items.valid;
      for (int i = 2; i <= 6; i++) begin
        if (adv[i]) v[i] <= v[i-1];
      end
    end
  end

  // Stage 1: one-minus and one-plus terms, and the squares of the coordinates.
  always_comb begin
    smx_c = qsde_pkg::ONE_Q14 - {items.xi_coord[15], items.xi_coord};
    spx_c = qsde_pkg::ONE_Q14 + {items.xi_coord[15], items.xi_coord};
    smy_c = qsde_pkg::ONE_Q14 - {items.eta_coord[15], items.eta_coord};
    spy_c = qsde_pkg::ONE_Q14 + {items.eta_coord[15], items.eta_coord};
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      x1   <= items.xi_coord;
      y1   <= items.eta_coord;
      m1   <= items.node_mask;
      smx1 <= smx_c;
      spx1 <= spx_c;
      smy1 <= smy_c;
      spy1 <= spy_c;
      xsq1 <= items.xi_coord * items.xi_coord;
      ysq1 <= items.eta_coord * items.eta_coord;
    end
  end

  // Stage 2: quadratic bubbles, bilinear products and coordinate products.
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      m2    <= m1;
      smx2  <= smx1;
      spx2  <= spx1;
      smy2  <= smy1;
      spy2  <= spy1;
      qx2   <= qsde_pkg::ONE_SQ - xsq1;
      qy2   <= qsde_pkg::ONE_SQ - ysq1;
      pmm2  <= smx1 * smy1;
      ppm2  <= spx1 * smy1;
      ppp2  <= spx1 * spy1;
      pmp2  <= smx1 * spy1;
      xsmy2 <= x1 * smy1;
      xspy2 <= x1 * spy1;
      yspx2 <= y1 * spx1;
      ysmx2 <= y1 * smx1;
    end
  end

  // Stage 3: midside value products.
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      m3    <= m2;
      smx3  <= smx2;
      spx3  <= spx2;
      smy3  <= smy2;
      spy3  <= spy2;
      qx3   <= qx2;
      qy3   <= qy2;
      pmm3  <= pmm2;
      ppm3  <= ppm2;
      ppp3  <= ppp2;
      pmp3  <= pmp2;
      xsmy3 <= xsmy2;
      xspy3 <= xspy2;
      yspx3 <= yspx2;
      ysmx3 <= ysmx2;
      mq4_3 <= qx2 * smy2;
      mq5_3 <= qy2 * spx2;
      mq6_3 <= qx2 * spy2;
      mq7_3 <= qy2 * smx2;
    end
  end

  // Stage 4: scale every term to 2^44; absent midsides become zero.
  always_comb begin
    nv_c[4] = qsde_pkg::wide_t'(mq4_3) <<< 1;
    dx_c[4] = -(qsde_pkg::wide_t'(xsmy3) <<< 16);
    dy_c[4] = -(qsde_pkg::wide_t'(qx3) <<< 15);
    nv_c[5] = qsde_pkg::wide_t'(mq5_3) <<< 1;
    dx_c[5] = qsde_pkg::wide_t'(qy3) <<< 15;
    dy_c[5] = -(qsde_pkg::wide_t'(yspx3) <<< 16);
    nv_c[6] = qsde_pkg::wide_t'(mq6_3) <<< 1;
    dx_c[6] = -(qsde_pkg::wide_t'(xspy3) <<< 16);
    dy_c[6] = qsde_pkg::wide_t'(qx3) <<< 15;
    nv_c[7] = qsde_pkg::wide_t'(mq7_3) <<< 1;
    dx_c[7] = -(qsde_pkg::wide_t'(qy3) <<< 15);
    dy_c[7] = -(qsde_pkg::wide_t'(ysmx3) <<< 16);
    for (int k = 4; k < 8; k++) begin
      if (!m3[k]) begin
        nv_c[k] = '0;
        dx_c[k] = '0;
        dy_c[k] = '0;
      end
    end
    nv_c[0] = qsde_pkg::wide_t'(pmm3) <<< 14;
    dx_c[0] = -(qsde_pkg::wide_t'(smy3) <<< 28);
    dy_c[0] = -(qsde_pkg::wide_t'(smx3) <<< 28);
    nv_c[1] = qsde_pkg::wide_t'(ppm3) <<< 14;
    dx_c[1] = qsde_pkg::wide_t'(smy3) <<< 28;
    dy_c[1] = -(qsde_pkg::wide_t'(spx3) <<< 28);
    nv_c[2] = qsde_pkg::wide_t'(ppp3) <<< 14;
    dx_c[2] = qsde_pkg::wide_t'(spy3) <<< 28;
    dy_c[2] = qsde_pkg::wide_t'(spx3) <<< 28;
    nv_c[3] = qsde_pkg::wide_t'(pmp3) <<< 14;
    dx_c[3] = -(qsde_pkg::wide_t'(spy3) <<< 28);
    dy_c[3] = qsde_pkg::wide_t'(smx3) <<< 28;
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      m4 <= m3;
      for (int k = 0; k < 8; k++) begin
        nv4[k] <= nv_c[k];
        dx4[k] <= dx_c[k];
        dy4[k] <= dy_c[k];
      end
    end
  end

  // Stage 5: each corner loses half of its two neighbouring midsides. The
  // midside terms are all even, so the halving shift is exact.
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      nvk_c[k] = nv4[k];
      dxk_c[k] = dx4[k];
      dyk_c[k] = dy4[k];
    end
    for (int k = 0; k < 4; k++) begin
      nvk_c[k] = nv4[k] - ((nv4[(k == 0) ? 7 : k + 3] + nv4[k+4]) >>> 1);
      dxk_c[k] = dx4[k] - ((dx4[(k == 0) ? 7 : k + 3] + dx4[k+4]) >>> 1);
      dyk_c[k] = dy4[k] - ((dy4[(k == 0) ? 7 : k + 3] + dy4[k+4]) >>> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      m5 <= m4;
      for (int k = 0; k < 8; k++) begin
        nv5[k] <= nvk_c[k];
        dx5[k] <= dxk_c[k];
        dy5[k] <= dyk_c[k];
      end
    end
  end

  // Stage 6: floor to scale 2^14 and saturate.
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      res_c[k].shape = floor_sat(nv5[k]);
      res_c[k].dxi   = floor_sat(dx5[k]);
      res_c[k].deta  = floor_sat(dy5[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      m6   <= m5;
      res6 <= res_c;
    end
  end

  assign set_valid     = v[6];
  assign set_data.mask = m6;
  assign set_data.res  = res6;

`ifndef SYNTH
  // A held result set keeps its mask while the sequencer is busy.
  a_hold_set: assert property (@(posedge clk) disable iff (rst)
    (v[6] && !set_ready) |=> (v[6] && $stable(m6)))
    else $error("qsde_arith: stalled result set changed");

  // An accepted transaction occupies the first stage on the next cycle.
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready) |=> v[1])
    else $error("qsde_arith: accepted transaction lost at entry");

  // A moving item carries its mask from stage five into stage six.
  a_move: assert property (@(posedge clk) disable iff (rst)
    (v[5] && adv[6]) |=> (v[6] && m6 == $past(m5)))
    else $error("qsde_arith: item lost between stages five and six");
`endif

endmodule

// ----- rtl/qsde_serial.sv -----
// ----------------------------------------------------------------------------
// qsde_serial
// Output sequencer: holds one item's eight node results and sends the present
// nodes one per transaction in ascending node order, flagging the last one.
// ----------------------------------------------------------------------------
module qsde_serial (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 set_valid,
  output logic                 set_ready,
  input  qsde_pkg::node_set_t  set_data,
  qsde_out_if.source           results
);

  logic [qsde_pkg::MASK_W-1:0]     pending;
  qsde_pkg::node_res_t             res [qsde_pkg::N_NODES];
  logic [qsde_pkg::NODE_W-1:0]     first;
  logic                            single;
  logic                            take;
  logic                            load;

  // Lowest node still to be sent.
  always_comb begin
    first = '0;
    for (int k = qsde_pkg::N_NODES - 1; k >= 0; k--) begin
      if (pending[k]) first = qsde_pkg::NODE_W'(k);
    end
  end

  assign single    = (pending & (pending - 1'b1)) == '0;
  assign take      = results.valid && results.ready;
  assign set_ready = (pending == '0) || (take && single);
  assign load      = set_valid && set_ready;

  // Pending mask and held result set.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (load) begin
      pending <= set_data.mask;
    end else if (take) begin
      pending <= pending & ~(qsde_pkg::MASK_W'(1) << first);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < qsde_pkg::N_NODES; k++) begin
        res[k] <= set_data.res[k];
      end
    end
  end

  // Result channel driven from the held set.
  assign results.valid       = pending != '0;
  assign results.node_index  = first;
  assign results.shape_value = res[first].shape;
  assign results.deriv_xi    = res[first].dxi;
  assign results.deriv_eta   = res[first].deta;
  assign results.last_node   = single;

`ifndef SYNTH
  // A stalled transaction keeps the remaining node set unchanged.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.ready) |=> $stable(pending))
    else $error("qsde_serial: pending nodes changed during a stall");

  // Each sent node removes exactly one node from the pending set.
  a_count: assert property (@(posedge clk) disable iff (rst)
    (take && !load) |=> ($countones(pending) == $countones($past(pending)) - 1))
    else $error("qsde_serial: node count did not drop by one");

  // A loaded set starts with its full mask.
  a_load: assert property (@(posedge clk) disable iff (rst)
    load |=> (pending == $past(set_data.mask)))
    else $error("qsde_serial: loaded mask not taken over");
`endif

endmodule

// ----- rtl/quad_shape_and_derivative_eval.sv -----
// Result path: an accepted input transaction passes the six arithmetic stages
// and then the output sequencer before its first result is offered.
// An item sends one result transaction per present node (eight for a full
// mask); an empty mask sends no result transaction.
// The six-stage arithmetic pipeline takes a new item every cycle while it has room.
// Reset clears the valid bits and pending node set; input is not ready in reset.
// ----------------------------------------------------------------------------
// quad_shape_and_derivative_eval
// Shape functions and natural derivatives of a 4-to-8 node transition
// quadrilateral, one result transaction per present node.
// ----------------------------------------------------------------------------
module quad_shape_and_derivative_eval (
  input  logic       clk,
  input  logic       rst,
  qsde_in_if.sink    items,
  qsde_out_if.source results
);

  logic                set_valid;
  logic                set_ready;
  qsde_pkg::node_set_t set_data;

  // Arithmetic pipeline.
  qsde_arith u_arith (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .set_valid (set_valid),
    .set_ready (set_ready),
    .set_data  (set_data)
  );

  // Output sequencer.
  qsde_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .set_valid (set_valid),
    .set_ready (set_ready),
    .set_data  (set_data),
    .results   (results)
  );

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the transition quadrilateral shape function
// evaluator. Points and node masks are offered in random bursts. Each accepted
// transaction is turned into one expected node result per present node by a
// predictor that works on exact 64-bit terms. Results are compared field by
// field as they leave, while the result side stalls on a changing pattern and
// once holds off for a long stretch.
// ----------------------------------------------------------------------------
module tb;

  // One point offered on the input channel.
  typedef struct {
    logic signed [qsde_pkg::COORD_W-1:0] xi;
    logic signed [qsde_pkg::COORD_W-1:0] eta;
    logic [qsde_pkg::MASK_W-1:0]         mask;
  } point_t;

  // One expected node result.
  typedef struct {
    logic [qsde_pkg::NODE_W-1:0] idx;
    qsde_pkg::out_val_t          shape;
    qsde_pkg::out_val_t          dxi;
    qsde_pkg::out_val_t          deta;
    logic                        last;
  } node_exp_t;

  localparam longint UNIT   = 16384;
  localparam longint P14    = longint'(1) <<< 14;
  localparam longint P15    = longint'(1) <<< 15;
  localparam longint P16    = longint'(1) <<< 16;
  localparam longint P28    = longint'(1) <<< 28;
  localparam int     HOLD_CYCLES = 180;
  localparam int     HOLD_AFTER  = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  qsde_in_if  pts_if ();
  qsde_out_if res_if ();

  quad_shape_and_derivative_eval i_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (pts_if),
    .results (res_if)
  );

  point_t    pending_pts[$];
  node_exp_t node_queue[$];

  logic offer_live  = 1'b0;
  int   gap_left    = 0;
  int   burst_left  = 0;
  int   points_taken = 0;
  int   empty_masks = 0;
  int   nodes_seen  = 0;
  int   errors      = 0;
  int   hold_left   = 0;
  logic hold_done   = 1'b0;
  int   stall_cyc   = 0;

  always #6 clk = ~clk;

  // Floor a scale 2^44 term to scale 2^14 and saturate to the result range.
  function automatic qsde_pkg::out_val_t floor_to_out(longint v);
    longint r;
    r = v >>> qsde_pkg::FLOOR_SH;
    if (r > qsde_pkg::OUT_MAX) r = qsde_pkg::OUT_MAX;
    if (r < qsde_pkg::OUT_MIN) r = qsde_pkg::OUT_MIN;
    return qsde_pkg::out_val_t'(r);
  endfunction

  // Work out the node results of one point and append them to node_queue.
  function automatic void predict_node_results(point_t p);
    longint x, y, smx, spx, smy, spy, qx, qy;
    longint nv[qsde_pkg::N_NODES];
    longint dx[qsde_pkg::N_NODES];
    longint dy[qsde_pkg::N_NODES];
    int a, b, top;
    node_exp_t e;
    x   = longint'(p.xi);
    y   = longint'(p.eta);
    smx = UNIT - x;
    spx = UNIT + x;
    smy = UNIT - y;
    spy = UNIT + y;
    qx  = UNIT * UNIT - x * x;
    qy  = UNIT * UNIT - y * y;

    // Midside functions, zero where the node is absent.
    nv[4] = qx * smy * 2;  dx[4] = -x * smy * P16;  dy[4] = -qx * P15;
    nv[5] = qy * spx * 2;  dx[5] = qy * P15;        dy[5] = -y * spx * P16;
    nv[6] = qx * spy * 2;  dx[6] = -x * spy * P16;  dy[6] = qx * P15;
    nv[7] = qy * smx * 2;  dx[7] = -qy * P15;       dy[7] = -y * smx * P16;
    for (int k = 4; k < qsde_pkg::N_NODES; k++) begin
      if (!p.mask[k]) begin
        nv[k] = 0;
        dx[k] = 0;
        dy[k] = 0;
      end
    end

    // Bilinear corners, each less half of its two neighbouring midsides.
    nv[0] = smx * smy * P14;  dx[0] = -smy * P28;  dy[0] = -smx * P28;
    nv[1] = spx * smy * P14;  dx[1] = smy * P28;   dy[1] = -spx * P28;
    nv[2] = spx * spy * P14;  dx[2] = spy * P28;   dy[2] = spx * P28;
    nv[3] = smx * spy * P14;  dx[3] = -spy * P28;  dy[3] = smx * P28;
    for (int k = 0; k < 4; k++) begin
      a = (k == 0) ? 7 : k + 3;
      b = k + 4;
      nv[k] -= (nv[a] + nv[b]) / 2;
      dx[k] -= (dx[a] + dx[b]) / 2;
      dy[k] -= (dy[a] + dy[b]) / 2;
    end

    top = -1;
    for (int k = 0; k < qsde_pkg::N_NODES; k++)
      if (p.mask[k]) top = k;

    for (int k = 0; k < qsde_pkg::N_NODES; k++) begin
      if (p.mask[k]) begin
        e.idx   = qsde_pkg::NODE_W'(k);
        e.shape = floor_to_out(nv[k]);
        e.dxi   = floor_to_out(dx[k]);
        e.deta  = floor_to_out(dy[k]);
        e.last  = (k == top);
        node_queue.push_back(e);
      end
    end
  endfunction

  function automatic void queue_point(int xi, int eta, int mask);
    point_t p;
    p.xi   = qsde_pkg::COORD_W'(xi);
    p.eta  = qsde_pkg::COORD_W'(eta);
    p.mask = qsde_pkg::MASK_W'(mask);
    pending_pts.push_back(p);
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (!rst && !offer_live) begin
      if (gap_left > 0) begin
        gap_left--;
        pts_if.valid <= 1'b0;
      end else if (pending_pts.size() > 0) begin
        pts_if.xi_coord  <= pending_pts[0].xi;
        pts_if.eta_coord <= pending_pts[0].eta;
        pts_if.node_mask <= pending_pts[0].mask;
        pts_if.valid     <= 1'b1;
        offer_live = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        pts_if.valid <= 1'b0;
      end
    end
  end

  // Input monitor: predict the results of every accepted transaction.
  always @(posedge clk) begin
    point_t p;
    if (!rst && pts_if.valid && pts_if.ready) begin
      p.xi   = pts_if.xi_coord;
      p.eta  = pts_if.eta_coord;
      p.mask = pts_if.node_mask;
      predict_node_results(p);
      if (p.mask == '0) empty_masks++;
      void'(pending_pts.pop_front());
      offer_live = 1'b0;
      points_taken <= points_taken + 1;
    end
  end

  // Long hold-off of the result side, started once the run is under way.
  always @(posedge clk) begin
    if (!rst) begin
      if (!hold_done && points_taken >= HOLD_AFTER) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // Receiver: the stall pattern steps through four patterns in turn, starting with always ready.
  always @(negedge clk) begin
    logic pat;
    if (!rst) begin
      case ((stall_cyc / 50) % 4)
        0: pat = 1'b1;
        1: pat = 1'($urandom_range(0, 1));
        2: pat = ($urandom_range(0, 3) == 0);
        default: pat = ((stall_cyc % 3) != 0);
      endcase
      res_if.ready <= (hold_left == 0) && pat;
      stall_cyc++;
    end
  end

  // Result monitor: compare each transaction with the oldest expectation.
  always @(posedge clk) begin
    node_exp_t e;
    if (!rst && res_if.valid && res_if.ready) begin
      nodes_seen++;
      if (node_queue.size() == 0) begin
        $error("unexpected node result: node_index %0d", res_if.node_index);
        errors++;
      end else begin
        e = node_queue.pop_front();
        if (res_if.node_index !== e.idx) begin
          $error("node_index: expected %0d, got %0d", e.idx, res_if.node_index);
          errors++;
        end
        if (res_if.shape_value !== e.shape) begin
          $error("shape_value: expected %0d, got %0d", e.shape, res_if.shape_value);
          errors++;
        end
        if (res_if.deriv_xi !== e.dxi) begin
          $error("deriv_xi: expected %0d, got %0d", e.dxi, res_if.deriv_xi);
          errors++;
        end
        if (res_if.deriv_eta !== e.deta) begin
          $error("deriv_eta: expected %0d, got %0d", e.deta, res_if.deriv_eta);
          errors++;
        end
        if (res_if.last_node !== e.last) begin
          $error("last_node: expected %0d, got %0d", e.last, res_if.last_node);
          errors++;
        end
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int sel, xi, eta, mask;
    pts_if.valid     = 1'b0;
    pts_if.xi_coord  = '0;
    pts_if.eta_coord = '0;
    pts_if.node_mask = '0;
    res_if.ready     = 1'b0;

    // Directed points: corners of the square, far outside it, an empty mask,
    // single nodes, and each corner together with its two midsides.
    queue_point(0, 0, 8'hFF);
    queue_point(-16384, -16384, 8'hFF);
    queue_point(16384, 16384, 8'hFF);
    queue_point(16384, -16384, 8'hFF);
    queue_point(-16384, 16384, 8'hFF);
    queue_point(0, 0, 8'h00);
    queue_point(8192, -4096, 8'h0F);
    queue_point(-32768, -32768, 8'hFF);
    queue_point(32767, 32767, 8'hFF);
    queue_point(-32768, 32767, 8'hFF);
    for (int k = 0; k < qsde_pkg::N_NODES; k++)
      queue_point(5000, -7000, 1 << k);
    queue_point(12345, -2345, 8'h80);
    queue_point(-9000, 3000, 8'h91);
    queue_point(4321, -1234, 8'h32);
    queue_point(-15000, 15000, 8'h64);
    queue_point(777, 16000, 8'hC8);
    queue_point(0, 0, 8'h00);
    queue_point(-1, 1, 8'hAA);

    // Random points: mostly inside the element, some with xi on an edge or on the
    // centre line, some anywhere in the 16-bit range.
    for (int n = 0; n < 145; n++) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        xi  = int'($urandom_range(0, 32768)) - 16384;
        eta = int'($urandom_range(0, 32768)) - 16384;
      end else if (sel == 7) begin
        xi  = 16384 * (int'($urandom_range(0, 2)) - 1);
        eta = int'($urandom_range(0, 32768)) - 16384;
      end else begin
        xi  = int'($urandom_range(0, 65535)) - 32768;
        eta = int'($urandom_range(0, 65535)) - 32768;
      end
      sel = $urandom_range(0, 19);
      if (sel < 11)       mask = 8'h0F | (int'($urandom_range(0, 15)) << 4);
      else if (sel < 17)  mask = $urandom_range(0, 255);
      else if (sel == 17) mask = 8'h00;
      else                mask = 8'hFF;
      queue_point(xi, eta, mask);
    end

    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (pending_pts.size() != 0 || offer_live || node_queue.size() != 0)
      @(posedge clk);
    // Give the pipeline time to show any stray result.
    repeat (20) @(posedge clk);

    $display("Run covered %0d points (%0d with no node present) and %0d node results,",
             points_taken, empty_masks, nodes_seen);
    $display("with random bursts, receiver stalls and one %0d-cycle hold-off.",
             HOLD_CYCLES);
    if (errors == 0 && node_queue.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(12 * 300000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
